// ===== design/ieu_pkg.sv =====
// Shared types and codes for the IR instruction execute unit.
// Used by ieu_ctrl, ieu_datapath and ir_instruction_execute_unit; no dependencies.
package ieu_pkg;

    typedef enum logic [3:0] {
        OP_MOV = 4'd0,
        OP_LDR = 4'd1,
        OP_STR = 4'd2,
        OP_ADD = 4'd3,
        OP_SUB = 4'd4,
        OP_MUL = 4'd5,
        OP_DIV = 4'd6,
        OP_RET = 4'd7,
        OP_CMP = 4'd8,
        OP_JMP = 4'd9,
        OP_JEQ = 4'd10,
        OP_JLT = 4'd11,
        OP_JGT = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        KIND_REG   = 2'd0,
        KIND_IMM   = 2'd1,
        KIND_ADDR  = 2'd2,
        KIND_LABEL = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_BAD_KIND = 3'd1,
        STS_ADDR     = 3'd2,
        STS_DIV_ZERO = 3'd3,
        STS_UNKNOWN  = 3'd4,
        STS_BAD_REG  = 3'd5,
        STS_HALTED   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        FLAG_NONE = 2'd0,
        FLAG_EQ   = 2'd1,
        FLAG_LT   = 2'd2,
        FLAG_GT   = 2'd3
    } flag_t;

    // how the controller sequences an item
    typedef enum logic [2:0] {
        CLS_NONE = 3'd0,
        CLS_ALU  = 3'd1,
        CLS_MUL  = 3'd2,
        CLS_DIV  = 3'd3,
        CLS_LD   = 3'd4,
        CLS_ST   = 3'd5
    } cls_t;

    localparam logic REG_IDX_MEM_LIMIT = 1'b0;
    localparam logic REG_IDX_PROG_LEN  = 1'b1;

    localparam logic [12:0] MEM_LIMIT_RESET = 13'd4096;
    localparam logic [15:0] PROG_LEN_RESET  = 16'd65535;

    typedef struct packed {
        logic       load;
        logic       clr;
        logic       rd_issue;
        logic [1:0] rd_slot;
        logic       exec;
        logic       mul_go;
        logic       mul_addr;
        logic       addr_go;
        logic       div_start;
        logic       div_step;
        logic       mem_rd;
        logic       mem_wr;
        logic       ld_cap;
        logic       commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        cls_t cls;
        logic range_bad;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/ieu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ieu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;
endmodule

// ===== design/ieu_ctrl.sv =====
// Controller state machine of the execute unit: sequences clear, operand reads,
// execution, memory access and commit. Depends on ieu_pkg.
module ieu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ieu_pkg::dp_stat_t stat,
    output ieu_pkg::dp_cmd_t  cmd
);
    import ieu_pkg::*;

    typedef enum logic [15:0] {
        ST_CLEAR = 16'h0001,
        ST_IDLE  = 16'h0002,
        ST_RD0   = 16'h0004,
        ST_RD1   = 16'h0008,
        ST_RD2   = 16'h0010,
        ST_RD3   = 16'h0020,
        ST_DISP  = 16'h0040,
        ST_EXEC  = 16'h0080,
        ST_MUL   = 16'h0100,
        ST_AMUL  = 16'h0200,
        ST_AADD  = 16'h0400,
        ST_MEM   = 16'h0800,
        ST_MWAIT = 16'h1000,
        ST_DIVS  = 16'h2000,
        ST_DIVR  = 16'h4000,
        ST_FIN   = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD0;
                end
            end
            ST_RD0: begin
                if (stat.cls == CLS_NONE) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.rd_issue = 1'b1;
                    cmd.rd_slot  = 2'd0;
                    state_next   = ST_RD1;
                end
            end
            ST_RD1: begin
                cmd.rd_issue = 1'b1;
                cmd.rd_slot  = 2'd1;
                state_next   = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_issue = 1'b1;
                cmd.rd_slot  = 2'd2;
                state_next   = ST_RD3;
            end
            ST_RD3: begin
                cmd.rd_issue = 1'b1;
                cmd.rd_slot  = 2'd3;
                state_next   = ST_DISP;
            end
            ST_DISP: begin
                case (stat.cls)
                    CLS_ALU:         state_next = ST_EXEC;
                    CLS_MUL:         state_next = ST_MUL;
                    CLS_DIV:         state_next = ST_DIVS;
                    CLS_LD, CLS_ST:  state_next = ST_AMUL;
                    default:         state_next = ST_FIN;
                endcase
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_FIN;
            end
            ST_MUL: begin
                cmd.mul_go = 1'b1;
                state_next = ST_FIN;
            end
            ST_AMUL: begin
                cmd.mul_go   = 1'b1;
                cmd.mul_addr = 1'b1;
                state_next   = ST_AADD;
            end
            ST_AADD: begin
                cmd.addr_go = 1'b1;
                state_next  = ST_MEM;
            end
            ST_MEM: begin
                if (stat.range_bad) begin
                    state_next = ST_FIN;
                end else if (stat.cls == CLS_LD) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_MWAIT;
                end else begin
                    cmd.mem_wr = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_MWAIT: begin
                cmd.ld_cap = 1'b1;
                state_next = ST_FIN;
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVR;
            end
            ST_DIVR: begin
                if (stat.div_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_RD0))
        else $error("load did not enter operand read");
    a_no_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> !cmd.clr)
        else $error("clear pass restarted after idle");
    a_mem_rd_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_rd |=> cmd.ld_cap)
        else $error("load data not captured after read");
endmodule

// ===== design/ieu_datapath.sv =====
// Datapath of the execute unit: item registers, register file, byte lanes of
// data memory, multiplier, divider and result register. Depends on ieu_pkg, ieu_ram.
module ieu_datapath #(
    parameter int REG_COUNT = 8,
    parameter int MEM_BYTES = 4096,
    parameter int IP_BITS   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ieu_pkg::dp_cmd_t    cmd,
    output ieu_pkg::dp_stat_t   stat,
    input  logic [12:0]         mem_limit,
    input  logic [15:0]         prog_len,
    input  logic [3:0]          s_command,
    input  logic [1:0]          s_first_kind,
    input  logic [31:0]         s_first_value,
    input  logic [1:0]          s_second_kind,
    input  logic [31:0]         s_second_value,
    input  logic [1:0]          s_third_kind,
    input  logic [31:0]         s_third_value,
    input  logic [31:0]         s_addr_base,
    input  logic signed [3:0]   s_addr_plain_reg,
    input  logic signed [3:0]   s_addr_scaled_reg,
    input  logic signed [31:0]  s_addr_scale,
    input  logic signed [16:0]  s_jump_target,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic                m_reg_write,
    output logic [2:0]          m_written_reg,
    output logic [31:0]         m_written_value,
    output logic [1:0]          m_compare_flag,
    output logic                m_took_jump,
    output logic [15:0]         m_next_pointer,
    output logic                m_halted
);
    import ieu_pkg::*;

    localparam int RA   = $clog2(REG_COUNT);
    localparam int AW   = $clog2(MEM_BYTES);
    localparam int ROWS = MEM_BYTES / 4;
    localparam int RW   = $clog2(ROWS);
    localparam logic [32:0] RC33  = 33'(REG_COUNT);
    localparam logic [32:0] MEM33 = 33'(MEM_BYTES);

    // item registers
    logic [3:0]  cmd_reg;
    logic [1:0]  k1_reg, k2_reg, k3_reg;
    logic [31:0] v1_reg, v2_reg, v3_reg, base_reg, scale_reg;
    logic [3:0]  rp_reg, rs_reg;
    logic [16:0] tgt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= s_command;
            k1_reg    <= s_first_kind;
            v1_reg    <= s_first_value;
            k2_reg    <= s_second_kind;
            v2_reg    <= s_second_value;
            k3_reg    <= s_third_kind;
            v3_reg    <= s_third_value;
            base_reg  <= s_addr_base;
            rp_reg    <= s_addr_plain_reg;
            rs_reg    <= s_addr_scaled_reg;
            scale_reg <= s_addr_scale;
            tgt_reg   <= s_jump_target;
        end
    end

    // architectural state
    logic [1:0]         flag_reg;
    logic [IP_BITS-1:0] ip_reg;
    logic               stopped_reg;

    // decode and checks
    logic    rp_use, rs_use, rp_bad, rs_bad;
    logic    bad1, bad2, bad3, val1, val2, val3;
    logic    halt_pre, unknown, kinds_ok, regs_ok, is_jump, is_ret;
    status_t st_pre;
    cls_t    cls;

    assign rp_use = !rp_reg[3];
    assign rs_use = !rs_reg[3];
    assign rp_bad = rp_use && (33'(rp_reg[2:0]) >= RC33);
    assign rs_bad = rs_use && (33'(rs_reg[2:0]) >= RC33);
    assign bad1   = (k1_reg == KIND_REG) && ({1'b0, v1_reg} >= RC33);
    assign bad2   = (k2_reg == KIND_REG) && ({1'b0, v2_reg} >= RC33);
    assign bad3   = (k3_reg == KIND_REG) && ({1'b0, v3_reg} >= RC33);
    assign val1   = (k1_reg == KIND_REG) || (k1_reg == KIND_IMM);
    assign val2   = (k2_reg == KIND_REG) || (k2_reg == KIND_IMM);
    assign val3   = (k3_reg == KIND_REG) || (k3_reg == KIND_IMM);

    assign halt_pre = stopped_reg || (33'(ip_reg) >= 33'(prog_len));
    assign unknown  = (cmd_reg > OP_JGT);
    assign is_jump  = (cmd_reg >= OP_JMP) && !unknown;
    assign is_ret   = (cmd_reg == OP_RET);

    always_comb begin
        kinds_ok = 1'b1;
        regs_ok  = 1'b1;
        case (cmd_reg)
            OP_MOV: begin
                kinds_ok = (k1_reg == KIND_REG) && val2;
                regs_ok  = !bad1 && !bad2;
            end
            OP_LDR: begin
                kinds_ok = (k1_reg == KIND_REG) && (k2_reg == KIND_ADDR);
                regs_ok  = !bad1 && !rp_bad && !rs_bad;
            end
            OP_STR: begin
                kinds_ok = val1 && (k2_reg == KIND_ADDR);
                regs_ok  = !bad1 && !rp_bad && !rs_bad;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                kinds_ok = (k1_reg == KIND_REG) && val2 && val3;
                regs_ok  = !bad1 && !bad2 && !bad3;
            end
            OP_CMP: begin
                kinds_ok = val1 && val2;
                regs_ok  = !bad1 && !bad2;
            end
            OP_JMP, OP_JEQ, OP_JLT, OP_JGT: begin
                kinds_ok = (k1_reg == KIND_LABEL);
            end
            default: begin
                kinds_ok = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (halt_pre)       st_pre = STS_HALTED;
        else if (unknown)   st_pre = STS_UNKNOWN;
        else if (!kinds_ok) st_pre = STS_BAD_KIND;
        else if (!regs_ok)  st_pre = STS_BAD_REG;
        else                st_pre = STS_OK;
    end

    always_comb begin
        cls = CLS_NONE;
        if (st_pre == STS_OK && !is_jump && !is_ret) begin
            case (cmd_reg)
                OP_MOV, OP_ADD, OP_SUB, OP_CMP: cls = CLS_ALU;
                OP_MUL:  cls = CLS_MUL;
                OP_DIV:  cls = CLS_DIV;
                OP_LDR:  cls = CLS_LD;
                OP_STR:  cls = CLS_ST;
                default: cls = CLS_NONE;
            endcase
        end
    end

    // operand slots: x, y, plain address reg, scaled address reg
    logic [31:0] slot_idx   [4];
    logic [31:0] slot_imm   [4];
    logic        slot_isreg [4];

    always_comb begin
        if (cmd_reg == OP_STR || cmd_reg == OP_CMP) begin
            slot_idx[0]   = v1_reg;
            slot_isreg[0] = (k1_reg == KIND_REG);
        end else begin
            slot_idx[0]   = v2_reg;
            slot_isreg[0] = (k2_reg == KIND_REG);
        end
        if (cmd_reg == OP_CMP) begin
            slot_idx[1]   = v2_reg;
            slot_isreg[1] = (k2_reg == KIND_REG);
        end else begin
            slot_idx[1]   = v3_reg;
            slot_isreg[1] = (k3_reg == KIND_REG);
        end
        slot_idx[2]   = 32'(rp_reg[2:0]);
        slot_isreg[2] = rp_use;
        slot_idx[3]   = 32'(rs_reg[2:0]);
        slot_isreg[3] = rs_use;
        slot_imm[0]   = slot_idx[0];
        slot_imm[1]   = slot_idx[1];
        slot_imm[2]   = '0;
        slot_imm[3]   = '0;
    end

    // register file with per-entry valid bits so reset reads as zero
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [RA-1:0]        rf_raddr, rf_waddr;
    logic [31:0]          rf_rdata, rf_wdata;
    logic                 rf_we, rd_valid_reg, rd_pend_reg;
    logic [1:0]           rd_slot_reg;
    logic [31:0]          op_reg [4];

    assign rf_raddr = RA'(slot_idx[cmd.rd_slot]);

    ieu_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    always_ff @(posedge aclk) begin
        rd_valid_reg <= rf_valid_reg[rf_raddr];
        rd_slot_reg  <= cmd.rd_slot;
        if (rd_pend_reg) begin
            op_reg[rd_slot_reg] <= slot_isreg[rd_slot_reg]
                                   ? (rd_valid_reg ? rf_rdata : 32'd0)
                                   : slot_imm[rd_slot_reg];
        end
    end

    // alu and compare
    logic [31:0] alu_reg;
    logic [1:0]  cmp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            case (cmd_reg)
                OP_ADD:  alu_reg <= op_reg[0] + op_reg[1];
                OP_SUB:  alu_reg <= op_reg[0] - op_reg[1];
                default: alu_reg <= op_reg[0];
            endcase
            if (op_reg[0] == op_reg[1])     cmp_reg <= FLAG_EQ;
            else if (op_reg[0] < op_reg[1]) cmp_reg <= FLAG_LT;
            else                            cmp_reg <= FLAG_GT;
        end
    end

    // shared multiplier: product of mul, or scale times index register
    logic [31:0] mul_a, mul_b, prod_reg;
    assign mul_a = cmd.mul_addr ? scale_reg : op_reg[0];
    assign mul_b = cmd.mul_addr ? op_reg[3] : op_reg[1];

    always_ff @(posedge aclk) begin
        if (cmd.mul_go) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // effective address and range check
    logic [31:0] addr_reg, addr_next;
    logic        range_bad_reg;
    logic [32:0] lim33;

    assign lim33     = (33'(mem_limit) < MEM33) ? 33'(mem_limit) : MEM33;
    assign addr_next = base_reg + op_reg[2] + prod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.addr_go) begin
            addr_reg      <= addr_next;
            range_bad_reg <= ({1'b0, addr_next} + 33'd4) > lim33;
        end
    end

    // restoring divider, one quotient bit per cycle; divisor zero gives all ones
    logic [31:0] rem_reg, quo_reg;
    logic [5:0]  dcnt_reg;
    logic [32:0] div_sh, div_diff;

    assign div_sh   = {rem_reg, quo_reg[31]};
    assign div_diff = div_sh - {1'b0, op_reg[1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= 6'd32;
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= op_reg[0];
        end else if (cmd.div_step) begin
            if (!div_diff[32]) begin
                rem_reg <= div_diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= div_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    // data memory as four byte lanes; lane = byte address mod 4
    logic [RW:0]   clr_cnt_reg;
    logic [RW-1:0] clr_row;
    logic [1:0]    off;
    logic [RW-1:0] row_base;
    logic [7:0]    lane_rd [4];
    logic [31:0]   ld_reg, ld_next;

    assign clr_row  = clr_cnt_reg[RW-1:0];
    assign off      = addr_reg[1:0];
    assign row_base = addr_reg[AW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [1:0]    k;
        logic [RW-1:0] row;
        logic [7:0]    wbyte;
        assign k     = 2'(l) - off;
        assign row   = row_base + RW'(2'(l) < off);
        assign wbyte = 8'(op_reg[0] >> {k, 3'b000});

        ieu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
            .aclk  (aclk),
            .we    (cmd.clr || cmd.mem_wr),
            .waddr (cmd.clr ? clr_row : row),
            .wdata (cmd.clr ? 8'd0 : wbyte),
            .raddr (row),
            .rdata (lane_rd[l])
        );
    end

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            ld_next[8*b +: 8] = lane_rd[2'(off + 2'(b))];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_cap) begin
            ld_reg <= ld_next;
        end
    end

    // commit
    logic               mem_cls, wr_now, jump_now, cond;
    status_t            st_fin;
    logic [31:0]        wval;
    logic [1:0]         flag_next;
    logic [IP_BITS-1:0] ip_next;
    logic               stopped_next;

    assign mem_cls = (cls == CLS_LD) || (cls == CLS_ST);
    assign wr_now  = (cls == CLS_LD) ? !range_bad_reg
                   : ((cls != CLS_NONE) && (cls != CLS_ST) && (cmd_reg != OP_CMP));

    always_comb begin
        if (st_pre != STS_OK)                   st_fin = st_pre;
        else if (mem_cls && range_bad_reg)      st_fin = STS_ADDR;
        else if (cls == CLS_DIV && op_reg[1] == 32'd0) st_fin = STS_DIV_ZERO;
        else                                    st_fin = STS_OK;
    end

    always_comb begin
        case (cls)
            CLS_MUL: wval = prod_reg;
            CLS_DIV: wval = quo_reg;
            CLS_LD:  wval = ld_reg;
            default: wval = alu_reg;
        endcase
    end

    always_comb begin
        case (cmd_reg)
            OP_JMP:  cond = 1'b1;
            OP_JEQ:  cond = (flag_reg == FLAG_EQ);
            OP_JLT:  cond = (flag_reg == FLAG_LT);
            OP_JGT:  cond = (flag_reg == FLAG_GT);
            default: cond = 1'b0;
        endcase
    end

    assign jump_now  = (st_pre == STS_OK) && is_jump && cond && !tgt_reg[16];
    assign flag_next = (cls == CLS_ALU && cmd_reg == OP_CMP) ? cmp_reg : flag_reg;

    always_comb begin
        stopped_next = stopped_reg;
        if (st_pre == STS_HALTED) begin
            ip_next = ip_reg;
        end else if (st_pre == STS_UNKNOWN) begin
            ip_next      = ip_reg;
            stopped_next = 1'b1;
        end else if (jump_now) begin
            ip_next = IP_BITS'({16'd0, tgt_reg[15:0]});
        end else begin
            ip_next = ip_reg + 1'b1;
        end
    end

    assign rf_we    = cmd.commit && wr_now;
    assign rf_waddr = RA'(v1_reg);
    assign rf_wdata = wval;

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
            flag_reg     <= FLAG_NONE;
            ip_reg       <= '0;
            stopped_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_issue;
            if (cmd.commit) begin
                flag_reg    <= flag_next;
                ip_reg      <= ip_next;
                stopped_reg <= stopped_next;
                m_valid_reg <= 1'b1;
                if (wr_now) begin
                    rf_valid_reg[rf_waddr] <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status        <= st_fin;
            m_reg_write     <= wr_now;
            m_written_reg   <= wr_now ? 3'(v1_reg) : 3'd0;
            m_written_value <= wr_now ? wval : 32'd0;
            m_compare_flag  <= flag_next;
            m_took_jump     <= jump_now;
            m_next_pointer  <= 16'(ip_next);
            m_halted        <= stopped_next || (33'(ip_next) >= 33'(prog_len));
        end
    end

    assign m_valid = m_valid_reg;

    assign stat.clr_last  = (clr_row == RW'(ROWS - 1));
    assign stat.cls       = cls;
    assign stat.range_bad = range_bad_reg;
    assign stat.div_done  = (dcnt_reg == 6'd0);
    assign stat.out_free  = !m_valid_reg || m_ready;

    a_store_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> !range_bad_reg)
        else $error("store issued outside the memory limit");
    a_div_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (dcnt_reg != 6'd0))
        else $error("divider stepped past its last bit");
    a_wr_index: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_we |-> ({1'b0, v1_reg} < RC33))
        else $error("register write to an index beyond the file");
    a_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr |-> !(cmd.mem_wr || cmd.commit))
        else $error("clear pass overlaps item work");
endmodule

// ===== design/ir_instruction_execute_unit.sv =====
// Top level of the IR instruction execute unit: configuration registers,
// controller and datapath. Depends on ieu_pkg, ieu_ctrl, ieu_datapath, ieu_ram.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  s_       | s_valid / s_ready      | decoded instruction and operands
//  m_       | m_valid / m_ready      | status, register write, flag, pointer
//  apb      | psel/penable/pready    | memory_limit @0, program_length @4
//
// Halted, rejected, ret and jump items go straight to commit; mov, add,
// sub, cmp and mul read operands, then execute; ldr and str read operands,
// then do an address multiply, add and byte-lane access; div steps one
// quotient bit a cycle. After reset a clearing pass writes zero to data
// memory, row by row, with s_ready low. One item is in flight; a finished
// result waits in the output register and the next item is taken meanwhile.
module ir_instruction_execute_unit #(
    parameter int REG_COUNT = 8,
    parameter int MEM_BYTES = 4096,
    parameter int IP_BITS   = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_command,
    input  logic [1:0]         s_first_kind,
    input  logic [31:0]        s_first_value,
    input  logic [1:0]         s_second_kind,
    input  logic [31:0]        s_second_value,
    input  logic [1:0]         s_third_kind,
    input  logic [31:0]        s_third_value,
    input  logic [31:0]        s_addr_base,
    input  logic signed [3:0]  s_addr_plain_reg,
    input  logic signed [3:0]  s_addr_scaled_reg,
    input  logic signed [31:0] s_addr_scale,
    input  logic signed [16:0] s_jump_target,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic               m_reg_write,
    output logic [2:0]         m_written_reg,
    output logic [31:0]        m_written_value,
    output logic [1:0]         m_compare_flag,
    output logic               m_took_jump,
    output logic [15:0]        m_next_pointer,
    output logic               m_halted
);
    import ieu_pkg::*;

    logic [12:0] mem_limit_reg;
    logic [15:0] prog_len_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_limit_reg <= MEM_LIMIT_RESET;
            prog_len_reg  <= PROG_LEN_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_IDX_MEM_LIMIT: mem_limit_reg <= pwdata[12:0];
                REG_IDX_PROG_LEN:  prog_len_reg  <= pwdata[15:0];
                default:           prog_len_reg  <= prog_len_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IDX_MEM_LIMIT: prdata = 32'(mem_limit_reg);
            REG_IDX_PROG_LEN:  prdata = 32'(prog_len_reg);
            default:           prdata = '0;
        endcase
    end

    ieu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ieu_datapath #(
        .REG_COUNT (REG_COUNT),
        .MEM_BYTES (MEM_BYTES),
        .IP_BITS   (IP_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .mem_limit         (mem_limit_reg),
        .prog_len          (prog_len_reg),
        .s_command         (s_command),
        .s_first_kind      (s_first_kind),
        .s_first_value     (s_first_value),
        .s_second_kind     (s_second_kind),
        .s_second_value    (s_second_value),
        .s_third_kind      (s_third_kind),
        .s_third_value     (s_third_value),
        .s_addr_base       (s_addr_base),
        .s_addr_plain_reg  (s_addr_plain_reg),
        .s_addr_scaled_reg (s_addr_scaled_reg),
        .s_addr_scale      (s_addr_scale),
        .s_jump_target     (s_jump_target),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_reg_write       (m_reg_write),
        .m_written_reg     (m_written_reg),
        .m_written_value   (m_written_value),
        .m_compare_flag    (m_compare_flag),
        .m_took_jump       (m_took_jump),
        .m_next_pointer    (m_next_pointer),
        .m_halted          (m_halted)
    );
endmodule

// ===== tb/ir_instruction_execute_unit_test.sv =====
// Self-checking bench for ir_instruction_execute_unit: an instruction driver, a result
// monitor and an APB writer around a cycle-free model of the machine state.
// Depends on ieu_pkg and the RTL of the execute unit.
module ir_instruction_execute_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ieu_pkg::*;

    localparam int NREG = 8;
    localparam int NMEM = 4096;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [3:0]         command;
        logic [1:0]         k1;
        logic [31:0]        v1;
        logic [1:0]         k2;
        logic [31:0]        v2;
        logic [1:0]         k3;
        logic [31:0]        v3;
        logic [31:0]        base;
        logic signed [3:0]  plain;
        logic signed [3:0]  scaled;
        logic signed [31:0] scale;
        logic signed [16:0] target;
    } instr_t;

    typedef struct {
        logic [2:0]  status;
        logic        reg_write;
        logic [2:0]  wreg;
        logic [31:0] wval;
        logic [1:0]  flag;
        logic        jumped;
        logic [15:0] ptr;
        logic        halted;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready;
    logic [3:0] s_command = '0;
    logic [1:0] s_first_kind = '0, s_second_kind = '0, s_third_kind = '0;
    logic [31:0] s_first_value = '0, s_second_value = '0, s_third_value = '0;
    logic [31:0] s_addr_base = '0;
    logic signed [3:0] s_addr_plain_reg = '0, s_addr_scaled_reg = '0;
    logic signed [31:0] s_addr_scale = '0;
    logic signed [16:0] s_jump_target = '0;
    logic m_valid, m_ready = 1'b0;
    logic [2:0] m_status, m_written_reg;
    logic m_reg_write, m_took_jump, m_halted;
    logic [31:0] m_written_value;
    logic [1:0] m_compare_flag;
    logic [15:0] m_next_pointer;

    ir_instruction_execute_unit dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // machine state as the unit should hold it
    logic [31:0] regs [NREG];
    logic [7:0]  mem [NMEM];
    logic [1:0]  flag;
    logic [15:0] ip;
    logic        stopped;
    logic [12:0] mem_limit;
    logic [15:0] prog_len;

    instr_t   pending_instrs [$];
    outcome_t expected_outcomes [$];
    int errors = 0, accepted = 0, results = 0, idle_cycles = 0;
    int hold_off = 0;
    bit timed_out = 0;
    int cnt_status [8];

    function automatic logic value_kind(logic [1:0] k);
        return k == KIND_REG || k == KIND_IMM;
    endfunction

    function automatic logic reg_fine(logic [1:0] k, logic [31:0] v);
        return k != KIND_REG || v < NREG;
    endfunction

    function automatic logic [31:0] fetch(logic [1:0] k, logic [31:0] v);
        return k == KIND_REG ? regs[v[2:0]] : v;
    endfunction

    function automatic outcome_t execute(instr_t t);
        outcome_t o;
        logic ok_kinds, wr, adv;
        logic [31:0] a, x, y, wv;
        logic [2:0] st, wr_idx;
        int lim;
        o = '{default: '0};
        st = STS_OK; wr = 0; wv = 0; wr_idx = 0; adv = 1;
        lim = mem_limit < NMEM ? mem_limit : NMEM;
        if (stopped || ip >= prog_len) begin
            st = STS_HALTED; adv = 0;
        end else if (t.command > OP_JGT) begin
            st = STS_UNKNOWN; stopped = 1; adv = 0;
        end else if (t.command <= OP_STR) begin
            ok_kinds = (t.command == OP_STR) ? value_kind(t.k1) : t.k1 == KIND_REG;
            ok_kinds = ok_kinds && (t.command == OP_MOV ? value_kind(t.k2)
                                                        : t.k2 == KIND_ADDR);
            if (!ok_kinds) st = STS_BAD_KIND;
            else if (!reg_fine(t.k1, t.v1) ||
                     (t.command == OP_MOV && !reg_fine(t.k2, t.v2)))
                st = STS_BAD_REG;
            else if (t.command == OP_MOV) begin
                wr = 1; wr_idx = t.v1[2:0]; wv = fetch(t.k2, t.v2);
            end else begin
                a = t.base;
                if (t.plain >= 0) a += regs[t.plain[2:0]];
                if (t.scaled >= 0) a += t.scale * regs[t.scaled[2:0]];
                if ({32'd0, a} + 64'd4 > lim) st = STS_ADDR;
                else if (t.command == OP_LDR) begin
                    wr = 1; wr_idx = t.v1[2:0];
                    wv = {mem[a+3], mem[a+2], mem[a+1], mem[a]};
                end else begin
                    x = fetch(t.k1, t.v1);
                    {mem[a+3], mem[a+2], mem[a+1], mem[a]} = x;
                end
            end
        end else if (t.command <= OP_DIV) begin
            if (t.k1 != KIND_REG || !value_kind(t.k2) || !value_kind(t.k3))
                st = STS_BAD_KIND;
            else if (!reg_fine(t.k1, t.v1) || !reg_fine(t.k2, t.v2) ||
                     !reg_fine(t.k3, t.v3))
                st = STS_BAD_REG;
            else begin
                x = fetch(t.k2, t.v2); y = fetch(t.k3, t.v3);
                wr = 1; wr_idx = t.v1[2:0];
                case (t.command)
                    OP_ADD: wv = x + y;
                    OP_SUB: wv = x - y;
                    OP_MUL: wv = x * y;
                    default: begin
                        if (y == 0) begin
                            wv = '1; st = STS_DIV_ZERO;
                        end else wv = x / y;
                    end
                endcase
            end
        end else if (t.command == OP_CMP) begin
            if (!value_kind(t.k1) || !value_kind(t.k2)) st = STS_BAD_KIND;
            else if (!reg_fine(t.k1, t.v1) || !reg_fine(t.k2, t.v2)) st = STS_BAD_REG;
            else begin
                x = fetch(t.k1, t.v1); y = fetch(t.k2, t.v2);
                flag = x == y ? FLAG_EQ : (x < y ? FLAG_LT : FLAG_GT);
            end
        end else if (t.command != OP_RET) begin
            if (t.k1 != KIND_LABEL) st = STS_BAD_KIND;
            else if ((t.command == OP_JMP || (t.command == OP_JEQ && flag == FLAG_EQ) ||
                      (t.command == OP_JLT && flag == FLAG_LT) ||
                      (t.command == OP_JGT && flag == FLAG_GT)) && t.target >= 0) begin
                ip = t.target[15:0]; o.jumped = 1; adv = 0;
            end
        end
        if (wr) regs[wr_idx] = wv;
        if (adv) ip = ip + 16'd1;
        o.status = st; o.reg_write = wr; o.wreg = wr ? wr_idx : 3'd0;
        o.wval = wr ? wv : 32'd0; o.flag = flag; o.ptr = ip;
        o.halted = stopped || ip >= prog_len;
        return o;
    endfunction

    // driver
    int gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_outcomes.push_back(execute(pending_instrs.pop_front()));
                accepted++;
                gap = $urandom_range(0, 3);
            end
            if ((!s_valid || s_ready) ) begin
                if (gap == 0 && pending_instrs.size() > 0) begin
                    s_valid <= 1'b1;
                    s_command <= pending_instrs[0].command;
                    s_first_kind <= pending_instrs[0].k1;
                    s_first_value <= pending_instrs[0].v1;
                    s_second_kind <= pending_instrs[0].k2;
                    s_second_value <= pending_instrs[0].v2;
                    s_third_kind <= pending_instrs[0].k3;
                    s_third_value <= pending_instrs[0].v3;
                    s_addr_base <= pending_instrs[0].base;
                    s_addr_plain_reg <= pending_instrs[0].plain;
                    s_addr_scaled_reg <= pending_instrs[0].scaled;
                    s_addr_scale <= pending_instrs[0].scale;
                    s_jump_target <= pending_instrs[0].target;
                end else begin
                    s_valid <= 1'b0;
                    if (gap > 0) gap--;
                end
            end
        end
    end

    // monitor
    int wait_left = 0;
    always @(posedge aclk) begin
        outcome_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results++;
                idle_cycles = 0;
                if (expected_outcomes.size() == 0) begin
                    $display("%0t unexpected result status %0d", $time, m_status);
                    errors++;
                end else begin
                    e = expected_outcomes.pop_front();
                    cnt_status[e.status]++;
                    if ({m_status, m_reg_write, m_written_reg, m_written_value,
                         m_compare_flag, m_took_jump, m_next_pointer, m_halted} !==
                        {e.status, e.reg_write, e.wreg, e.wval, e.flag, e.jumped,
                         e.ptr, e.halted}) begin
                        $display("%0t mismatch exp st=%0d w=%0b r=%0d v=%h f=%0d j=%0b p=%0d h=%0b",
                                 $time, e.status, e.reg_write, e.wreg, e.wval, e.flag,
                                 e.jumped, e.ptr, e.halted);
                        $display("%0t          got st=%0d w=%0b r=%0d v=%h f=%0d j=%0b p=%0d h=%0b",
                                 $time, m_status, m_reg_write, m_written_reg,
                                 m_written_value, m_compare_flag, m_took_jump,
                                 m_next_pointer, m_halted);
                        errors++;
                    end
                end
                wait_left = $urandom_range(0, 3);
            end else if (s_valid && s_ready) idle_cycles = 0;
            else idle_cycles++;
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                m_ready <= (wait_left == 0);
                if (wait_left > 0) wait_left--;
            end else if (wait_left > 0) begin
                wait_left--;
                m_ready <= 1'b0;
            end else m_ready <= 1'b1;
            if (idle_cycles >= STALL_LIMIT && !timed_out) begin
                timed_out = 1;
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_IDX_MEM_LIMIT) mem_limit = value[12:0];
        else prog_len = value[15:0];
    endtask

    task automatic drain;
        while (pending_instrs.size() > 0 || expected_outcomes.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic signed [3:0] pick_reg();
        return $urandom_range(0, 9) == 0 ? -4'sd1 : 4'($urandom_range(0, 7));
    endfunction

    // mostly well-formed instructions with random content
    function automatic instr_t random_instr(input bit allow_unknown);
        instr_t t;
        t.command = (allow_unknown && $urandom_range(0, 99) < 3)
                    ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
        t.k1 = KIND_REG; t.k2 = KIND_IMM; t.k3 = KIND_REG;
        t.v1 = $urandom_range(0, 7); t.v2 = $urandom; t.v3 = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) t.v2 = $urandom_range(0, 7);
        if ($urandom_range(0, 1)) t.k2 = KIND_REG;
        if ($urandom_range(0, 1)) begin
            t.k3 = KIND_IMM; t.v3 = $urandom_range(0, 9) == 0 ? 0 : $urandom >> $urandom_range(0, 31);
        end
        t.base = $urandom_range(0, 4100);
        t.plain = pick_reg(); t.scaled = pick_reg();
        t.scale = $urandom_range(0, 2) == 0 ? $urandom : 32'($urandom_range(0, 4));
        if ($urandom_range(0, 1)) begin
            t.plain = -4'sd1; t.scaled = -4'sd1;
        end
        t.target = $urandom_range(0, 7) == 0 ? -17'sd1 : 17'($urandom_range(0, 300));
        if ($urandom_range(0, 30) == 0) t.target = 17'($urandom);
        case (t.command)
            OP_LDR: t.k2 = KIND_ADDR;
            OP_STR: begin
                t.k2 = KIND_ADDR; t.k1 = $urandom_range(0, 1) ? KIND_IMM : KIND_REG;
                if (t.k1 == KIND_IMM) t.v1 = $urandom;
            end
            OP_CMP: t.k1 = $urandom_range(0, 1) ? KIND_IMM : KIND_REG;
            OP_JMP, OP_JEQ, OP_JLT, OP_JGT: t.k1 = KIND_LABEL;
            default: ;
        endcase
        // noise: bad kinds, bad register indices and unused address registers
        if ($urandom_range(0, 19) == 0) t.k1 = 2'($urandom);
        if ($urandom_range(0, 19) == 0) t.k2 = 2'($urandom);
        if ($urandom_range(0, 19) == 0) t.k3 = 2'($urandom);
        if ($urandom_range(0, 24) == 0) t.v1 = $urandom;
        if ($urandom_range(0, 24) == 0) t.v3 = $urandom;
        if ($urandom_range(0, 24) == 0) t.plain = 4'($urandom_range(8, 15));
        if ($urandom_range(0, 24) == 0) t.scaled = 4'($urandom_range(8, 15));
        return t;
    endfunction

    function automatic instr_t mk(logic [3:0] c, logic [1:0] k1, logic [31:0] v1,
                                  logic [1:0] k2, logic [31:0] v2,
                                  logic [1:0] k3, logic [31:0] v3);
        instr_t t;
        t = '{command: c, k1: k1, v1: v1, k2: k2, v2: v2, k3: k3, v3: v3,
              base: 0, plain: -4'sd1, scaled: -4'sd1, scale: 0, target: 17'sd5};
        return t;
    endfunction

    initial begin
        instr_t t;
        foreach (regs[i]) regs[i] = 0;
        foreach (mem[i]) mem[i] = 0;
        flag = FLAG_NONE; ip = 0; stopped = 0;
        mem_limit = MEM_LIMIT_RESET; prog_len = PROG_LEN_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        apb_write(REG_IDX_MEM_LIMIT, 32'd4096);
        apb_write(REG_IDX_PROG_LEN, 32'd65535);

        // directed: extremes, every operation, each corner
        pending_instrs.push_back(mk(OP_MOV, KIND_REG, 1, KIND_IMM, 32'hFFFF_FFFF, KIND_REG, 0));
        pending_instrs.push_back(mk(OP_MOV, KIND_REG, 2, KIND_REG, 1, KIND_REG, 0));
        pending_instrs.push_back(mk(OP_ADD, KIND_REG, 3, KIND_REG, 1, KIND_IMM, 2));
        pending_instrs.push_back(mk(OP_SUB, KIND_REG, 4, KIND_IMM, 0, KIND_IMM, 1));
        pending_instrs.push_back(mk(OP_MUL, KIND_REG, 5, KIND_REG, 1, KIND_REG, 1));
        pending_instrs.push_back(mk(OP_DIV, KIND_REG, 6, KIND_IMM, 32'hFFFF_FFFF, KIND_IMM, 7));
        pending_instrs.push_back(mk(OP_DIV, KIND_REG, 7, KIND_IMM, 5, KIND_IMM, 0));
        t = mk(OP_STR, KIND_REG, 1, KIND_ADDR, 0, KIND_REG, 0); t.base = 4092;
        pending_instrs.push_back(t);
        t = mk(OP_LDR, KIND_REG, 0, KIND_ADDR, 0, KIND_REG, 0); t.base = 4092;
        pending_instrs.push_back(t);
        t.base = 4093; pending_instrs.push_back(t);
        t.base = 32'hFFFF_FFFE; pending_instrs.push_back(t);
        t = mk(OP_STR, KIND_IMM, 32'h1234_5678, KIND_ADDR, 0, KIND_REG, 0);
        t.base = 32'hFFFF_FF00; t.plain = 4'sd7; t.scaled = 4'sd4; t.scale = 32'h8000_0000;
        pending_instrs.push_back(t);
        pending_instrs.push_back(mk(OP_ADD, KIND_IMM, 1, KIND_IMM, 1, KIND_IMM, 1));
        pending_instrs.push_back(mk(OP_ADD, KIND_REG, 8, KIND_IMM, 1, KIND_IMM, 1));
        t = mk(OP_LDR, KIND_REG, 0, KIND_ADDR, 0, KIND_REG, 0); t.plain = 4'sd7;
        t.scaled = -4'sd8; pending_instrs.push_back(t);
        pending_instrs.push_back(mk(OP_RET, KIND_ADDR, 0, KIND_ADDR, 0, KIND_ADDR, 0));
        pending_instrs.push_back(mk(OP_CMP, KIND_REG, 1, KIND_IMM, 0, KIND_REG, 0));
        pending_instrs.push_back(mk(OP_JGT, KIND_LABEL, 0, KIND_REG, 0, KIND_REG, 0));
        pending_instrs.push_back(mk(OP_JEQ, KIND_LABEL, 0, KIND_REG, 0, KIND_REG, 0));
        pending_instrs.push_back(mk(OP_JLT, KIND_REG, 0, KIND_REG, 0, KIND_REG, 0));
        t = mk(OP_JMP, KIND_LABEL, 0, KIND_REG, 0, KIND_REG, 0); t.target = -17'sd1;
        pending_instrs.push_back(t);
        // jump high and straight back, so the pointer never reaches the end
        t.target = 17'sd65534; pending_instrs.push_back(t);
        t.target = 17'sd5; pending_instrs.push_back(t);
        pending_instrs.push_back(mk(OP_RET, KIND_REG, 0, KIND_REG, 0, KIND_REG, 0));
        drain();

        // random phases; an unknown opcode stops the machine for good, so those
        // come only in the last phase, which runs halted anyway
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) apb_write(REG_IDX_MEM_LIMIT, 32'd0);
            if (phase == 2) apb_write(REG_IDX_MEM_LIMIT, 32'h1FFF);
            if (phase == 3) apb_write(REG_IDX_MEM_LIMIT, 32'd64);
            apb_write(REG_IDX_PROG_LEN, phase == 3 ? 32'd0 : 32'hFFFF);
            for (int n = 0; n < 270; n++) pending_instrs.push_back(random_instr(phase == 3));
            if (phase == 0) begin
                repeat (30) @(posedge aclk);
                hold_off = 200;
            end
            drain();
        end

        // live unknown opcode last, then one item that sees the stopped machine
        apb_write(REG_IDX_PROG_LEN, 32'hFFFF);
        pending_instrs.push_back(mk(4'd15, KIND_REG, 0, KIND_REG, 0, KIND_REG, 0));
        pending_instrs.push_back(mk(OP_MOV, KIND_REG, 0, KIND_IMM, 1, KIND_REG, 0));
        drain();

        $display("run: %0d items, %0d results; ok %0d, bad kind %0d, range %0d, div0 %0d",
                 accepted, results, cnt_status[STS_OK], cnt_status[STS_BAD_KIND],
                 cnt_status[STS_ADDR], cnt_status[STS_DIV_ZERO]);
        $display("     unknown %0d, bad reg %0d, halted %0d",
                 cnt_status[STS_UNKNOWN], cnt_status[STS_BAD_REG], cnt_status[STS_HALTED]);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
design/ieu_pkg.sv
design/ieu_ram.sv
design/ieu_ctrl.sv
design/ieu_datapath.sv
design/ir_instruction_execute_unit.sv
tb/ir_instruction_execute_unit_test.sv
